@@ rtl/core/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, codes and constants of the duplicate contention tracker.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int RING_DEPTH  = 8;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int MAX_CATCHUP = 4;
  localparam int CATCH_W     = $clog2(MAX_CATCHUP + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REACTCAP = 3'd6;

  typedef enum logic [2:0] {
    FN_RETX    = 3'd0,
    FN_DUPE    = 3'd1,
    FN_EXTRACT = 3'd2,
    FN_HEAD    = 3'd3,
    FN_EXTEND  = 3'd4,
    FN_TICK    = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] pkt_hash;
    logic [31:0] now_ms;
    logic [15:0] air_ms;
    logic [15:0] ext_ms;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  dup_total;
    logic [15:0] headroom_ms;
    logic [15:0] ema_value;
    logic        warmed_up;
  } out_word_t;

  typedef struct packed {
    logic [15:0] watch_ms;
    logic [19:0] quiet_ms;
    logic [15:0] decay_step_ms;
    logic [2:0]  avg_shift;
    logic [7:0]  warmup_count;
    logic [9:0]  backoff_mult_q8;
    logic [15:0] reactive_cap_ms;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_FIN,
    ST_HMUL,
    ST_HEAD,
    ST_EXP,
    ST_STALE,
    ST_DECAY,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic act;
    logic fin;
    logic hmul;
    logic head;
    logic exp_step;
    logic stale;
    logic decay;
    logic result;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] func;
    logic       scan_last;
    logic       hit;
    logic       expired;
    logic       fin_need;
    logic       exp_last;
    logic       decay_go;
  } stat_t;

endpackage

@@ rtl/core/dct_ctrl.sv @@
// ----------------------------------------------------------------------------
// dct_ctrl
// Sequencer: walks the ring, finalizes, computes headroom, and runs decay steps on a tick.
// ----------------------------------------------------------------------------
module dct_ctrl import dct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_free,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;
  logic [CATCH_W-1:0] steps, steps_next;

  always_comb begin
    state_next = state;
    steps_next = steps;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_SCAN;
      ST_SCAN: if (stat.scan_last) begin
        if (stat.func == FN_TICK) state_next = ST_EXP;
        else if (stat.func == FN_HEAD) state_next = ST_HMUL;
        else state_next = ST_ACT;
      end
      ST_ACT:  state_next = stat.fin_need ? ST_FIN : ST_DONE;
      ST_FIN:  state_next = (stat.func == FN_TICK) ?
                            (stat.exp_last ? ST_STALE : ST_EXP) : ST_DONE;
      ST_HMUL: state_next = ST_HEAD;
      ST_HEAD: state_next = ST_DONE;
      ST_EXP:  begin
        if (stat.fin_need) state_next = ST_FIN;
        else if (stat.exp_last) state_next = ST_STALE;
      end
      ST_STALE: begin
        state_next = ST_DECAY;
        steps_next = '0;
      end
      ST_DECAY: begin
        if (stat.decay_go && steps != CATCH_W'(MAX_CATCHUP - 1)) begin
          steps_next = steps + 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:  cmd.load = in_fire;
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_ACT:   cmd.act = 1'b1;
      ST_FIN:   cmd.fin = 1'b1;
      ST_HMUL:  cmd.hmul = 1'b1;
      ST_HEAD:  cmd.head = 1'b1;
      ST_EXP:   cmd.exp_step = 1'b1;
      ST_STALE: cmd.stale = 1'b1;
      ST_DECAY: cmd.decay = 1'b1;
      ST_DONE:  cmd.result = out_free;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE)
    else $error("word accepted while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DECAY |-> steps < CATCH_W'(MAX_CATCHUP))
    else $error("decay catch-up overran");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> state != ST_FIN)
    else $error("back to back finalize");

endmodule

@@ rtl/core/dct_datapath.sv @@
// ----------------------------------------------------------------------------
// dct_datapath
// Ring storage, average, decay timing and result register.
// ----------------------------------------------------------------------------
module dct_datapath import dct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready
);

  logic [31:0] slot_hash       [RING_DEPTH];
  logic [31:0] slot_first_seen [RING_DEPTH];
  logic [7:0]  slot_dupes      [RING_DEPTH];
  logic [15:0] slot_reactive   [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_active;
  logic [SLOT_W-1:0] write_slot;
  logic [15:0] average;
  logic [7:0]  samples_done;
  logic [31:0] last_retx_time;
  logic [31:0] last_decay_time;

  in_word_t    cur;
  logic [SLOT_W-1:0] idx;       // scan pointer
  logic [SLOT_W-1:0] hit_idx;
  logic        hit;
  logic        fin_pending;
  logic [SLOT_W-1:0] fin_idx;
  logic [7:0]  fin_count;
  logic [25:0] per_prod;
  logic [19:0] cap12;
  logic        stale_ok;
  logic        stale_now;

  logic [31:0] age;
  logic        expired_i;
  assign age       = cur.now_ms - slot_first_seen[idx];
  assign expired_i = age > {16'd0, cfg.watch_ms};

  logic [31:0] hit_age;
  assign hit_age = cur.now_ms - slot_first_seen[hit_idx];

  // fold of a finalized count into the average
  logic [16:0] sample;
  logic [2:0]  sh;
  logic [16:0] avg_fold;
  logic [16:0] diff;
  logic [16:0] bias;
  always_comb begin
    sample = {1'b0, fin_count, 8'd0};
    sh     = (samples_done < cfg.warmup_count) ? 3'd1 : cfg.avg_shift;
    bias   = (17'd1 << sh) - 17'd1;
    if (samples_done < cfg.warmup_count && samples_done == 8'd0) begin
      diff     = '0;
      avg_fold = sample;
    end else if (sample >= {1'b0, average}) begin
      diff     = sample - {1'b0, average};
      avg_fold = {1'b0, average} + (diff >> sh);
    end else begin
      diff     = {1'b0, average} - sample + bias;
      avg_fold = {1'b0, average} - (diff >> sh);
    end
  end

  assign stale_now = last_retx_time != '0 && average != '0 &&
                     (cur.now_ms - last_retx_time) > {12'd0, cfg.quiet_ms};

  logic [31:0] since_decay;
  assign since_decay = cur.now_ms - last_decay_time;
  assign stat.decay_go = cmd.decay && stale_ok && average != 16'd0
                         && since_decay >= {16'd0, cfg.decay_step_ms};

  // headroom from registered products
  logic [17:0] per;
  logic [19:0] cap;
  logic [19:0] rem;
  logic [19:0] head;
  always_comb begin
    per  = per_prod[25:8];
    cap  = (cap12 > {4'd0, cfg.reactive_cap_ms}) ? {4'd0, cfg.reactive_cap_ms} : cap12;
    rem  = cap - {4'd0, slot_reactive[hit_idx]};
    head = '0;
    if (hit && per != '0 && {4'd0, slot_reactive[hit_idx]} < cap) begin
      head = ({2'd0, per} > rem) ? rem : {2'd0, per};
      if (head > 20'hFFFF) head = 20'hFFFF;
    end
  end

  logic [16:0] ext_sum;
  assign ext_sum = {1'b0, slot_reactive[hit_idx]} + {1'b0, cur.ext_ms};

  assign stat.func        = cur.func;
  assign stat.scan_last   = idx == SLOT_W'(RING_DEPTH - 1);
  assign stat.hit         = hit;
  assign stat.expired     = hit && hit_age > {16'd0, cfg.watch_ms};
  // entry to finalize in this update or expiry cycle
  assign stat.fin_need    = (cur.func == FN_RETX && slot_active[write_slot]) ||
                            (cur.func == FN_DUPE && stat.expired) ||
                            (cur.func == FN_EXTRACT && hit) ||
                            (cur.func == FN_TICK && slot_active[idx] && expired_i);
  assign stat.exp_last    = idx == SLOT_W'(RING_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active     <= '0;
      write_slot      <= '0;
      average         <= '0;
      samples_done    <= '0;
      last_retx_time  <= '0;
      last_decay_time <= '0;
      out_valid       <= 1'b0;
      fin_pending     <= 1'b0;
      hit             <= 1'b0;
      idx             <= '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        slot_hash[k]       <= '0;
        slot_first_seen[k] <= '0;
        slot_dupes[k]      <= '0;
        slot_reactive[k]   <= '0;
      end
    end else begin
      if (out_valid && out_ready && !cmd.result) out_valid <= 1'b0;
      if (cmd.load) begin
        cur         <= in_word;
        idx         <= '0;
        hit         <= 1'b0;
        fin_pending <= 1'b0;
      end
      if (cmd.scan_step) begin
        // lowest matching active entry wins
        if (!hit && slot_active[idx] && slot_hash[idx] == cur.pkt_hash) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end
        if (!stat.scan_last) idx <= idx + 1'b1;
        else idx <= '0;
      end
      if (cmd.act) begin
        unique case (cur.func)
          FN_RETX: begin
            last_retx_time <= cur.now_ms;
            if (slot_active[write_slot]) begin
              fin_pending <= 1'b1;
              fin_idx     <= write_slot;
              fin_count   <= slot_dupes[write_slot];
            end
          end
          FN_DUPE: if (hit) begin
            if (stat.expired) begin
              fin_pending <= 1'b1;
              fin_idx     <= hit_idx;
              fin_count   <= slot_dupes[hit_idx];
              hit         <= 1'b0;
            end else if (slot_dupes[hit_idx] != 8'hFF) begin
              slot_dupes[hit_idx] <= slot_dupes[hit_idx] + 8'd1;
            end
          end
          FN_EXTRACT: if (hit) begin
            fin_pending <= 1'b1;
            fin_idx     <= hit_idx;
            fin_count   <= slot_dupes[hit_idx];
          end
          FN_EXTEND: if (hit) begin
            slot_reactive[hit_idx] <= ext_sum[16] ? 16'hFFFF : ext_sum[15:0];
          end
          default: ;
        endcase
      end
      if (cmd.fin) begin
        average      <= avg_fold[15:0];
        if (samples_done != 8'hFF) samples_done <= samples_done + 8'd1;
        // a retransmit reuses the evicted slot at once
        slot_active[fin_idx] <= (cur.func == FN_RETX);
        fin_pending  <= 1'b0;
        if (cur.func == FN_RETX) begin
          // reload the freed slot
          slot_hash[write_slot]       <= cur.pkt_hash;
          slot_first_seen[write_slot] <= cur.now_ms;
          slot_dupes[write_slot]      <= '0;
          slot_reactive[write_slot]   <= '0;
          write_slot                  <= write_slot + 1'b1;
        end
        if (cur.func == FN_TICK && !stat.exp_last) idx <= idx + 1'b1;
      end
      if (cmd.act && cur.func == FN_RETX && !slot_active[write_slot]) begin
        slot_hash[write_slot]       <= cur.pkt_hash;
        slot_first_seen[write_slot] <= cur.now_ms;
        slot_dupes[write_slot]      <= '0;
        slot_reactive[write_slot]   <= '0;
        slot_active[write_slot]     <= 1'b1;
        write_slot                  <= write_slot + 1'b1;
      end
      if (cmd.hmul) begin
        per_prod <= {10'd0, cur.air_ms} * {16'd0, cfg.backoff_mult_q8};
        cap12    <= {cur.air_ms, 2'b0, 2'b0} - {2'b0, cur.air_ms, 2'b0};
      end
      if (cmd.exp_step) begin
        if (slot_active[idx] && expired_i) begin
          fin_pending <= 1'b1;
          fin_idx     <= idx;
          fin_count   <= slot_dupes[idx];
        end else if (!stat.exp_last) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.stale) begin
        if (stale_now) begin
          if (last_decay_time == '0)
            last_decay_time <= cur.now_ms - {16'd0, cfg.decay_step_ms};
        end else begin
          last_decay_time <= '0;
        end
      end
      if (stat.decay_go) begin
        average         <= average - (average >> cfg.avg_shift);
        last_decay_time <= last_decay_time + {16'd0, cfg.decay_step_ms};
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
        out_word.found       <= (cur.func == FN_DUPE || cur.func == FN_EXTRACT) && hit;
        out_word.dup_total   <= (cur.func == FN_EXTRACT && hit) ? fin_count : 8'd0;
        out_word.headroom_ms <= (cur.func == FN_HEAD) ? head[15:0] : 16'd0;
        out_word.ema_value   <= average;
        out_word.warmed_up   <= samples_done >= cfg.warmup_count;
      end
    end
  end

  // stale test latched at the start of the decay phase
  always_ff @(posedge clk) begin
    if (cmd.stale) begin
      stale_ok <= stale_now;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> fin_pending)
    else $error("finalize without pending entry");
  assert property (@(posedge clk) disable iff (rst)
    cmd.fin && cur.func != FN_TICK |=> !fin_pending)
    else $error("pending finalize not cleared");
  assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> !out_valid || out_ready)
    else $error("result register overwritten");

endmodule

@@ rtl/core/duplicate_contention_tracker.sv @@
// ----------------------------------------------------------------------------
// duplicate_contention_tracker
// Ring of recently retransmitted packets with duplicate counting and an
// average of contention.
// ----------------------------------------------------------------------------
// Usage: present a word on in_valid/in_data; in_ready is high while the
// block is free. Each input word gives exactly one result word on
// out_valid/out_data. Registers are written on cfg_valid/cfg_index/cfg_data;
// the user must write them only while idle; the block does not enforce it.
// cfg_ready is always high. Sequence: a word walks the ring one entry per
// cycle, then does the update and, if needed, the finalize, or the headroom
// products and headroom, then the result load. A tick walks the ring again,
// finalizing each expired entry it meets, then does one stale check and up
// to MAX_CATCHUP decay steps. One word at a time: in_ready returns the cycle
// after the result is loaded, so a new word is not taken before the result
// of the last one is loaded. Reset clears the ring, the average and the
// timers and loads register defaults. When the receiver stalls the result
// is held in the output register; a new word is still taken, but its result
// waits until the held one leaves.
// ----------------------------------------------------------------------------
module duplicate_contention_tracker import dct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  in_fire;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.watch_ms        <= 16'd5000;
      cfg.quiet_ms        <= 20'd30000;
      cfg.decay_step_ms   <= 16'd1000;
      cfg.avg_shift       <= 3'd3;
      cfg.warmup_count    <= 8'd4;
      cfg.backoff_mult_q8 <= 10'd256;
      cfg.reactive_cap_ms <= 16'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW:   cfg.watch_ms        <= cfg_data[15:0];
        REG_STALE:    cfg.quiet_ms        <= cfg_data[19:0];
        REG_PERIOD:   cfg.decay_step_ms   <= cfg_data[15:0];
        REG_SHIFT:    cfg.avg_shift       <= cfg_data[2:0];
        REG_WARMUP:   cfg.warmup_count    <= cfg_data[7:0];
        REG_BACKOFF:  cfg.backoff_mult_q8 <= cfg_data[9:0];
        REG_REACTCAP: cfg.reactive_cap_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (!out_valid || out_ready),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  dct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_word   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
